### hdl/text_console_scrollback_core_macros.svh
// Assertion macros for the text console scrollback core.
`ifndef TEXT_CONSOLE_SCROLLBACK_CORE_MACROS_SVH
`define TEXT_CONSOLE_SCROLLBACK_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TCS_ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcs: same-cycle check failed");
// Next-cycle implication.
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcs: next-cycle check failed");
`else
`define TCS_ASSERT_HOLDS(lbl, clk, rst, ante, cons)
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/tcs_pkg.sv
// Shared constants, types and helpers for the text console scrollback core.
`default_nettype none
package tcs_pkg;

   localparam int COLUMNS      = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int HISTORY_ROWS = 256;

   localparam int CELLS  = HISTORY_ROWS * COLUMNS;
   localparam int ROW_W  = $clog2(HISTORY_ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int VIEW_W = ((ROW_W > 6) ? ROW_W : 6) + 2;
   localparam int POS_W  = VIEW_W + COL_W;

   localparam logic [1:0] OP_CHAR = 2'd0;
   localparam logic [1:0] OP_KEY  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   localparam logic [7:0] SC_ALT_DOWN = 8'h38;
   localparam logic [7:0] SC_ALT_UP   = 8'hB8;
   localparam logic [7:0] SC_PG_UP    = 8'h49;
   localparam logic [7:0] SC_PG_DOWN  = 8'h51;
   localparam logic [7:0] SC_HOME     = 8'h47;
   localparam logic [7:0] SC_END      = 8'h4F;

   localparam logic [7:0]  RESET_COLOR = 8'h07;
   localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

   typedef struct packed {
      logic             wr;
      logic             rd;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [15:0]      data;
   } mem_cmd_type;

   // logical row to ring position
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] b);
      logic [ROW_W:0] s;
      s = {1'b0, r} + {1'b0, b};
      if (s >= (ROW_W+1)'(HISTORY_ROWS)) begin
         s = s - (ROW_W+1)'(HISTORY_ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

endpackage
`default_nettype wire

### hdl/tcs_req_if.sv
// Request channel: one console item.
`default_nettype none
interface tcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic [7:0] read_row;
   logic [6:0] read_col;

   modport source (output valid, operation, data_byte, read_row, read_col, input ready);
   modport sink (input valid, operation, data_byte, read_row, read_col, output ready);
endinterface
`default_nettype wire

### hdl/tcs_rsp_if.sv
// Response channel: console status after one request.
`default_nettype none
interface tcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_word;
   logic [7:0]  view_start_row;
   logic [10:0] cursor_position;
   logic        cursor_hidden;
   logic        key_consumed;
   logic [7:0]  cursor_row_now;
   logic [6:0]  cursor_col_now;

   modport source (output valid, cell_word, view_start_row, cursor_position, cursor_hidden,
                   key_consumed, cursor_row_now, cursor_col_now, input ready);
   modport sink (input valid, cell_word, view_start_row, cursor_position, cursor_hidden,
                 key_consumed, cursor_row_now, cursor_col_now, output ready);
endinterface
`default_nettype wire

### hdl/tcs_cell_store.sv
// Cell store: single-port synchronous RAM addressed by ring row and column.
`default_nettype none
module tcs_cell_store (
   input  wire                 clock,
   input  tcs_pkg::mem_cmd_type cmd,
   output logic [15:0]         rd_data_ff
);
   import tcs_pkg::*;

   logic [15:0]       mem [CELLS];
   logic [ADDR_W-1:0] addr;

   assign addr = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(COLUMNS)) + ADDR_W'(cmd.col);

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= cmd.data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule
`default_nettype wire

### hdl/text_console_scrollback_core.sv
// A request is taken in ST_IDLE; ST_DONE registers its response once the output is free.
// Work is one deep: no new request is taken until the last response is loaded.
// A request that scrolls past the last history row first blanks the new row in ST_BLANK.
// Reset: synchronous; afterwards the RAM is swept to blank cells, all HISTORY_ROWS * COLUMNS
// of them (20480), during which no request is taken; csr writes are taken outside reset.
`default_nettype none
`include "text_console_scrollback_core_macros.svh"
module text_console_scrollback_core (
   input  wire       clock,
   input  wire       reset,
   input  wire       csr_wr_en,
   input  wire [7:0] csr_wr_data,
   tcs_req_if.sink   req_chan,
   tcs_rsp_if.source rsp_chan
);
   import tcs_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_BLANK = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(HISTORY_ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [VIEW_W-1:0] PAGE     = VIEW_W'(SCREEN_ROWS - 1);

   logic [1:0]       state_ff, state_in;
   logic [ROW_W-1:0] sweep_row_ff, sweep_row_in;
   logic [COL_W-1:0] sweep_col_ff, sweep_col_in;
   logic [ROW_W-1:0] crow_ff, crow_in;
   logic [COL_W-1:0] ccol_ff, ccol_in;
   logic [ROW_W-1:0] view_ff, view_in;
   logic [ROW_W-1:0] base_ff, base_in;
   logic             alt_ff, alt_in;
   logic [7:0]       color_ff;
   logic             cell_ok_ff, cell_ok_in;
   logic             consumed_ff, consumed_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [15:0] rsp_cell_ff, rsp_cell_in;
   logic [7:0]  rsp_start_ff, rsp_start_in;
   logic [10:0] rsp_pos_ff, rsp_pos_in;
   logic        rsp_hidden_ff, rsp_hidden_in;
   logic        rsp_consumed_ff;
   logic [7:0]  rsp_row_ff, rsp_row_in;
   logic [6:0]  rsp_col_ff, rsp_col_in;

   mem_cmd_type cmd;
   logic [15:0] rd_data_ff;

   logic              req_fire, out_free, load_rsp, advance;
   logic [VIEW_W-1:0] crow_x, view_x, lim_x, view_up, vis_row;
   logic [COL_W:0]    tab_col;
   logic [POS_W-1:0]  pos;
   logic              rr_ok, rc_ok;

   tcs_cell_store u_store (
      .clock      (clock),
      .cmd        (cmd),
      .rd_data_ff (rd_data_ff)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load_rsp       = (state_ff == ST_DONE) && out_free;

   assign crow_x  = VIEW_W'(crow_ff);
   assign view_x  = VIEW_W'(view_ff);
   assign lim_x   = (crow_x >= PAGE) ? (crow_x - PAGE) : '0;
   assign view_up = view_x + PAGE;
   assign tab_col = ({1'b0, ccol_ff} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
   assign rr_ok   = int'(req_chan.read_row) < HISTORY_ROWS;
   assign rc_ok   = int'(req_chan.read_col) < COLUMNS;

   // response fields from the state left by the request
   assign vis_row       = (crow_x >= VIEW_W'(SCREEN_ROWS)) ? PAGE : crow_x;
   assign pos           = POS_W'(vis_row) * POS_W'(COLUMNS) + POS_W'(ccol_ff);
   assign rsp_hidden_in = (view_ff != '0);
   assign rsp_pos_in    = rsp_hidden_in ? 11'd0 : 11'(pos);
   assign rsp_start_in  = 8'(lim_x - view_x);
   assign rsp_cell_in   = cell_ok_ff ? rd_data_ff : 16'd0;
   assign rsp_row_in    = 8'(crow_ff);
   assign rsp_col_in    = 7'(ccol_ff);
   assign rsp_valid_in  = load_rsp || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      crow_in      = crow_ff;
      ccol_in      = ccol_ff;
      view_in      = view_ff;
      base_in      = base_ff;
      alt_in       = alt_ff;
      cell_ok_in   = cell_ok_ff;
      consumed_in  = consumed_ff;
      advance      = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr   = 1'b1;
            cmd.row  = sweep_row_ff;
            cmd.col  = sweep_col_ff;
            cmd.data = RESET_CELL;
            if (sweep_col_ff == COL_LAST) begin
               sweep_col_in = '0;
               if (sweep_row_ff == ROW_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  sweep_row_in = sweep_row_ff + 1'b1;
               end
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in    = ST_DONE;
               cell_ok_in  = 1'b0;
               consumed_in = 1'b0;
               case (req_chan.operation)
                  OP_CHAR: begin
                     view_in = '0;
                     if (req_chan.data_byte == CH_NL) begin
                        ccol_in = '0;
                        advance = 1'b1;
                     end else if (req_chan.data_byte == CH_CR) begin
                        ccol_in = '0;
                     end else if (req_chan.data_byte == CH_BS) begin
                        if (ccol_ff != '0) begin
                           ccol_in  = ccol_ff - 1'b1;
                           cmd.wr   = 1'b1;
                           cmd.row  = phys_row(crow_ff, base_ff);
                           cmd.col  = ccol_ff - 1'b1;
                           cmd.data = {color_ff, CH_SPACE};
                        end
                     end else if (req_chan.data_byte == CH_TAB) begin
                        if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                           ccol_in = '0;
                           advance = 1'b1;
                        end else begin
                           ccol_in = COL_W'(tab_col);
                        end
                     end else if (req_chan.data_byte >= CH_SPACE &&
                                  req_chan.data_byte < CH_DEL) begin
                        cmd.wr   = 1'b1;
                        cmd.row  = phys_row(crow_ff, base_ff);
                        cmd.col  = ccol_ff;
                        cmd.data = {color_ff, req_chan.data_byte};
                        if (ccol_ff == COL_LAST) begin
                           ccol_in = '0;
                           advance = 1'b1;
                        end else begin
                           ccol_in = ccol_ff + 1'b1;
                        end
                     end
                  end
                  OP_KEY: begin
                     case (req_chan.data_byte)
                        SC_ALT_DOWN: alt_in = 1'b1;
                        SC_ALT_UP:   alt_in = 1'b0;
                        SC_PG_UP: begin
                           consumed_in = 1'b1;
                           view_in     = ROW_W'((view_up > lim_x) ? lim_x : view_up);
                        end
                        SC_PG_DOWN: begin
                           consumed_in = 1'b1;
                           view_in     = ROW_W'((view_x >= PAGE) ? (view_x - PAGE) : '0);
                        end
                        SC_HOME: begin
                           if (alt_ff) begin
                              consumed_in = 1'b1;
                              view_in     = ROW_W'(lim_x);
                           end
                        end
                        SC_END: begin
                           if (alt_ff) begin
                              consumed_in = 1'b1;
                              view_in     = '0;
                           end
                        end
                        default: ;
                     endcase
                  end
                  OP_READ: begin
                     if (rr_ok && rc_ok) begin
                        cmd.rd     = 1'b1;
                        cmd.row    = phys_row(ROW_W'(req_chan.read_row), base_ff);
                        cmd.col    = COL_W'(req_chan.read_col);
                        cell_ok_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               if (advance) begin
                  if (crow_ff == ROW_LAST) begin
                     // ring scroll: oldest row becomes the new bottom row
                     base_in      = (base_ff == ROW_LAST) ? '0 : base_ff + 1'b1;
                     sweep_row_in = base_ff;
                     sweep_col_in = '0;
                     view_in      = '0;
                     state_in     = ST_BLANK;
                  end else begin
                     crow_in = crow_ff + 1'b1;
                  end
               end
            end
         end
         ST_BLANK: begin
            cmd.wr   = 1'b1;
            cmd.row  = sweep_row_ff;
            cmd.col  = sweep_col_ff;
            cmd.data = {color_ff, CH_SPACE};
            if (sweep_col_ff == COL_LAST) begin
               sweep_col_in = '0;
               state_in     = ST_DONE;
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_row_ff <= '0;
         sweep_col_ff <= '0;
         crow_ff      <= '0;
         ccol_ff      <= '0;
         view_ff      <= '0;
         base_ff      <= '0;
         alt_ff       <= 1'b0;
         color_ff     <= RESET_COLOR;
         cell_ok_ff   <= 1'b0;
         consumed_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_row_ff <= sweep_row_in;
         sweep_col_ff <= sweep_col_in;
         crow_ff      <= crow_in;
         ccol_ff      <= ccol_in;
         view_ff      <= view_in;
         base_ff      <= base_in;
         alt_ff       <= alt_in;
         cell_ok_ff   <= cell_ok_in;
         consumed_ff  <= consumed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_cell_ff     <= rsp_cell_in;
         rsp_start_ff    <= rsp_start_in;
         rsp_pos_ff      <= rsp_pos_in;
         rsp_hidden_ff   <= rsp_hidden_in;
         rsp_consumed_ff <= consumed_ff;
         rsp_row_ff      <= rsp_row_in;
         rsp_col_ff      <= rsp_col_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cell_word       = rsp_cell_ff;
   assign rsp_chan.view_start_row  = rsp_start_ff;
   assign rsp_chan.cursor_position = rsp_pos_ff;
   assign rsp_chan.cursor_hidden   = rsp_hidden_ff;
   assign rsp_chan.key_consumed    = rsp_consumed_ff;
   assign rsp_chan.cursor_row_now  = rsp_row_ff;
   assign rsp_chan.cursor_col_now  = rsp_col_ff;

   `TCS_ASSERT_HOLDS(a_view_within_limit, clock, reset, 1'b1, view_x <= lim_x)
   `TCS_ASSERT_HOLDS(a_col_in_range, clock, reset, 1'b1, {1'b0, ccol_ff} < (COL_W+1)'(COLUMNS))
   `TCS_ASSERT_HOLDS(a_blank_at_bottom, clock, reset, state_ff == ST_BLANK, crow_ff == ROW_LAST)
   `TCS_ASSERT_NEXT(a_char_ends_scrollback, clock, reset,
                    req_fire && req_chan.operation == OP_CHAR, view_ff == '0)
   `TCS_ASSERT_HOLDS(a_hidden_has_no_cursor, clock, reset,
                     rsp_valid_ff && rsp_hidden_ff, rsp_pos_ff == 11'd0)

endmodule
`default_nettype wire
